// ===== hdl/aard_pkg.sv =====
// shared types and constants of the audio activity range detector
package aard_pkg;

    localparam int TIMELINE_BITS = 36;
    localparam int TIME_BITS     = 48;
    localparam int SAMPLE_W      = 16;
    localparam int THR_W         = 16;
    localparam int GAP_W         = 27;
    localparam int RATE_W        = 19;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 27;

    // frame numbers handed to the converter carry one more bit (start plus length)
    localparam int FRAME_W = TIMELINE_BITS + 1;

    // twice the number of 100 ns units in one second
    localparam int                  HNS2_W       = 25;
    localparam logic [HNS2_W-1:0]   HNS2_PER_SEC = 25'd20000000;

    localparam logic [TIMELINE_BITS-1:0] FRAME_MAX = '1;
    localparam logic [TIME_BITS-1:0]     TIME_MAX  = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_GAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd2;

    localparam logic FUNC_FLUSH = 1'b1;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET   = 16'd512;
    localparam logic [GAP_W-1:0]  MERGE_GAP_RESET   = 27'd500000;
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = 19'd48000;

    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample;
        logic [TIMELINE_BITS-1:0]   frame_index;
        logic                       frame_end;
        logic                       packet_end;
    } t_in_item;

    typedef struct packed {
        logic [TIME_BITS-1:0] range_start_hns;
        logic [TIME_BITS-1:0] range_duration_hns;
    } t_out_item;

    // command from the front end to the back end
    typedef struct packed {
        logic                     is_flush;
        logic [TIMELINE_BITS-1:0] start_frame;
        logic [TIMELINE_BITS-1:0] run_length;
    } t_cmd;

    typedef struct packed {
        logic               start;
        logic [FRAME_W-1:0] frames;
    } t_conv_req;

    typedef struct packed {
        logic                 done;
        logic [TIME_BITS-1:0] hns;
    } t_conv_rsp;

endpackage

// ===== hdl/aard_fifo.sv =====
// small command queue between the front end and the back end
module aard_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  aard_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output aard_pkg::t_cmd o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aard_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/aard_front.sv =====
// front end: sample magnitude check, frame audibility and run tracking
module aard_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  aard_pkg::t_in_item            i_item,
    output logic                          o_stall,
    input  logic [aard_pkg::THR_W-1:0]    i_threshold,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output aard_pkg::t_cmd                o_cmd
);

    localparam int TL = aard_pkg::TIMELINE_BITS;

    logic          r_frame_audible;
    logic          r_in_run;
    logic [TL-1:0] r_run_start;
    logic [TL-1:0] r_run_length;

    logic                            accept;
    logic                            is_flush;
    logic [aard_pkg::SAMPLE_W-1:0]   raw;
    logic [aard_pkg::SAMPLE_W:0]     mag;
    logic                            audible;
    logic [TL-1:0]                   run_len_next;
    logic [TL-1:0]                   run_start_next;
    logic                            close_quiet;
    logic                            close_pkt;
    logic                            close;

    always_comb begin
        accept   = i_valid && !i_queue_full;
        is_flush = (i_item.func == aard_pkg::FUNC_FLUSH);
        raw      = $unsigned(i_item.sample);
        mag      = raw[aard_pkg::SAMPLE_W-1]
                 ? (17'h10000 - {1'b0, raw})
                 : {1'b0, raw};
        audible  = r_frame_audible || (mag >= {1'b0, i_threshold});

        if (!r_in_run) begin
            run_len_next   = TL'(1);
            run_start_next = i_item.frame_index;
        end else begin
            run_len_next   = (r_run_length == aard_pkg::FRAME_MAX)
                           ? r_run_length : r_run_length + 1'b1;
            run_start_next = r_run_start;
        end

        // a quiet frame closes the open run without itself
        close_quiet = !audible && r_in_run;
        close_pkt   = audible && i_item.packet_end;
        close       = i_item.frame_end && (close_quiet || close_pkt);

        o_stall = i_queue_full;
        o_push  = accept && (is_flush || close);

        o_cmd.is_flush    = is_flush;
        o_cmd.start_frame = close_quiet ? r_run_start  : run_start_next;
        o_cmd.run_length  = close_quiet ? r_run_length : run_len_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_audible <= 1'b0;
            r_in_run        <= 1'b0;
            r_run_start     <= '0;
            r_run_length    <= '0;
        end else if (accept && !is_flush) begin
            if (!i_item.frame_end) begin
                r_frame_audible <= audible;
            end else begin
                r_frame_audible <= 1'b0;
                if (close) begin
                    r_in_run     <= 1'b0;
                    r_run_length <= '0;
                end else if (audible) begin
                    r_in_run     <= 1'b1;
                    r_run_start  <= run_start_next;
                    r_run_length <= run_len_next;
                end
            end
        end
    end

endmodule

// ===== hdl/aard_conv.sv =====
// frame number to 100 ns time: split multiply, then bit-serial rounding division
module aard_conv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  aard_pkg::t_conv_req           i_req,
    input  logic [aard_pkg::RATE_W-1:0]   i_rate,
    output aard_pkg::t_conv_rsp           o_rsp
);

    localparam int FW    = aard_pkg::FRAME_W;
    localparam int KW    = aard_pkg::HNS2_W;
    localparam int TB    = aard_pkg::TIME_BITS;
    localparam int LO_W  = (FW + 1) / 2;
    localparam int HI_W  = FW - LO_W;
    localparam int NUM_W = FW + KW;
    localparam int REM_W = aard_pkg::RATE_W + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [2:0] {
        C_IDLE,
        C_MUL,
        C_ADD,
        C_DIV,
        C_SAT
    } t_conv_state;

    t_conv_state          r_state;
    logic [FW-1:0]        r_f;
    logic [LO_W+KW-1:0]   r_pl;
    logic [HI_W+KW-1:0]   r_ph;
    logic [NUM_W-1:0]     r_num;
    logic [NUM_W-1:0]     r_quo;
    logic [REM_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_done;
    logic [TB-1:0]        r_hns;

    logic [REM_W-1:0] divisor;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             ge;

    // round to nearest: (2*f*10^7 + rate) / (2*rate)
    always_comb begin
        divisor = {i_rate, 1'b0};
        trial   = {r_rem, r_num[NUM_W-1]};
        diff    = trial - {1'b0, divisor};
        ge      = (trial >= {1'b0, divisor});
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hns  = r_hns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        if (i_rate == '0) begin
                            r_hns  <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_f     <= i_req.frames;
                            r_state <= C_MUL;
                        end
                    end
                end
                C_MUL: begin
                    r_pl    <= (LO_W+KW)'(r_f[LO_W-1:0]) * (LO_W+KW)'(aard_pkg::HNS2_PER_SEC);
                    r_ph    <= (HI_W+KW)'(r_f[FW-1:LO_W]) * (HI_W+KW)'(aard_pkg::HNS2_PER_SEC);
                    r_state <= C_ADD;
                end
                C_ADD: begin
                    r_num   <= (NUM_W'(r_ph) << LO_W) + NUM_W'(r_pl) + NUM_W'(i_rate);
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= CNT_W'(NUM_W);
                    r_state <= C_DIV;
                end
                C_DIV: begin
                    r_rem   <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                    r_quo   <= {r_quo[NUM_W-2:0], ge};
                    r_num   <= {r_num[NUM_W-2:0], 1'b0};
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= C_SAT;
                    end
                end
                C_SAT: begin
                    r_hns   <= (|r_quo[NUM_W-1:TB]) ? aard_pkg::TIME_MAX : r_quo[TB-1:0];
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/aard_back.sv =====
// back end: run to time range, merge with the pending range, result register
module aard_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  aard_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    input  logic [aard_pkg::GAP_W-1:0]    i_gap,
    output aard_pkg::t_conv_req           o_conv_req,
    input  aard_pkg::t_conv_rsp           i_conv_rsp,
    output logic                          o_out_valid,
    output aard_pkg::t_out_item           o_out_item,
    input  logic                          i_out_stall
);

    localparam int TB = aard_pkg::TIME_BITS;
    localparam int FW = aard_pkg::FRAME_W;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CONV_S,
        B_WAIT_S,
        B_CONV_E,
        B_WAIT_E,
        B_PREP,
        B_DECIDE,
        B_APPLY,
        B_FLUSH
    } t_back_state;

    t_back_state          r_state;
    aard_pkg::t_cmd       r_cmd;
    logic [TB-1:0]        r_s;
    logic [TB-1:0]        r_e;
    logic [TB-1:0]        r_d;
    logic [TB:0]          r_pend_end;
    logic [TB:0]          r_new_end;
    logic                 r_merge;
    logic                 r_pend_valid;
    logic [TB-1:0]        r_pend_start;
    logic [TB-1:0]        r_pend_dur;
    logic                 r_out_valid;
    aard_pkg::t_out_item  r_out_item;

    logic          out_free;
    logic          out_load;
    logic [TB-1:0] d_calc;
    logic [TB+1:0] merge_lim;
    logic [TB:0]   s_plus_d;
    logic [TB:0]   merged_dur;
    logic [TB-1:0] merged_sat;

    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        // the pending range leaves on a flush or when a new range does not merge
        out_load  = r_pend_valid && out_free &&
                    (((r_state == B_APPLY) && !r_merge) || (r_state == B_FLUSH));
        d_calc    = (r_e > r_s) ? (r_e - r_s) : TB'(1);
        merge_lim = (TB+2)'(r_pend_end) + (TB+2)'(i_gap);
        s_plus_d  = (TB+1)'(r_s) + (TB+1)'(r_d);
        merged_dur = r_new_end - (TB+1)'(r_pend_start);
        if (merged_dur == '0) begin
            merged_sat = TB'(1);
        end else if (merged_dur[TB]) begin
            merged_sat = aard_pkg::TIME_MAX;
        end else begin
            merged_sat = merged_dur[TB-1:0];
        end

        o_pop = (r_state == B_IDLE) && !i_empty;
        o_conv_req.start  = (r_state == B_CONV_S) || (r_state == B_CONV_E);
        o_conv_req.frames = (r_state == B_CONV_S)
                          ? FW'(r_cmd.start_frame)
                          : FW'(r_cmd.start_frame) + FW'(r_cmd.run_length);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_pend_valid <= 1'b0;
            r_pend_start <= '0;
            r_pend_dur   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_state <= i_cmd.is_flush ? B_FLUSH : B_CONV_S;
                    end
                end
                B_CONV_S: begin
                    r_state <= B_WAIT_S;
                end
                B_WAIT_S: begin
                    if (i_conv_rsp.done) begin
                        r_s     <= i_conv_rsp.hns;
                        r_state <= B_CONV_E;
                    end
                end
                B_CONV_E: begin
                    r_state <= B_WAIT_E;
                end
                B_WAIT_E: begin
                    if (i_conv_rsp.done) begin
                        r_e     <= i_conv_rsp.hns;
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    r_d        <= d_calc;
                    r_pend_end <= (TB+1)'(r_pend_start) + (TB+1)'(r_pend_dur);
                    r_state    <= B_DECIDE;
                end
                B_DECIDE: begin
                    r_merge   <= r_pend_valid && ((TB+2)'(r_s) <= merge_lim);
                    r_new_end <= (s_plus_d > r_pend_end) ? s_plus_d : r_pend_end;
                    r_state   <= B_APPLY;
                end
                B_APPLY: begin
                    if (r_merge) begin
                        r_pend_dur <= merged_sat;
                        r_state    <= B_IDLE;
                    end else if (!r_pend_valid || out_free) begin
                        // push the old pending range out, the new one takes its place
                        if (r_pend_valid) begin
                            r_out_item.range_start_hns    <= r_pend_start;
                            r_out_item.range_duration_hns <= r_pend_dur;
                        end
                        r_pend_valid <= 1'b1;
                        r_pend_start <= r_s;
                        r_pend_dur   <= r_d;
                        r_state      <= B_IDLE;
                    end
                end
                B_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= B_IDLE;
                    end else if (out_free) begin
                        r_out_item.range_start_hns    <= r_pend_start;
                        r_out_item.range_duration_hns <= r_pend_dur;
                        r_pend_valid                  <= 1'b0;
                        r_pend_start                  <= '0;
                        r_pend_dur                    <= '0;
                        r_state                       <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/audio_activity_range_detector.sv =====
// top level of the audio activity range detector
// PCM samples come in one channel per request, tagged with frame number and
// frame-end / packet-end marks; a frame is audible when any channel magnitude
// reaches the threshold, and runs of audible frames become time ranges in
// 100 ns units that merge across short gaps. The front end takes every
// request as it comes while the queue has room. A request that closes a
// run, and a flush, leave a command in a QUEUE_DEPTH-entry queue;
// the input stalls only while that queue is full. The back end works on one
// command at a time: a closed run takes two frame-to-time conversions through
// the bit-serial divider that yields one quotient bit per cycle, then a merge
// step; a flush skips the conversions. A result waits in an output register
// and holds the back end only when the next one is ready.
module audio_activity_range_detector #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  aard_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output aard_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [aard_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aard_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [aard_pkg::THR_W-1:0]  r_threshold;
    logic [aard_pkg::GAP_W-1:0]  r_merge_gap;
    logic [aard_pkg::RATE_W-1:0] r_sample_rate;

    logic                 queue_full;
    logic                 queue_empty;
    logic                 push;
    logic                 pop;
    aard_pkg::t_cmd       push_cmd;
    aard_pkg::t_cmd       head_cmd;
    aard_pkg::t_conv_req  conv_req;
    aard_pkg::t_conv_rsp  conv_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= aard_pkg::THRESHOLD_RESET;
            r_merge_gap   <= aard_pkg::MERGE_GAP_RESET;
            r_sample_rate <= aard_pkg::SAMPLE_RATE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                aard_pkg::CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[aard_pkg::THR_W-1:0];
                end
                aard_pkg::CFG_MERGE_GAP: begin
                    r_merge_gap <= i_cfg_data[aard_pkg::GAP_W-1:0];
                end
                aard_pkg::CFG_SAMPLE_RATE: begin
                    r_sample_rate <= i_cfg_data[aard_pkg::RATE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    aard_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_item       (i_in_item),
        .o_stall      (o_in_stall),
        .i_threshold  (r_threshold),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    aard_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_data  (head_cmd)
    );

    aard_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (conv_req),
        .i_rate  (r_sample_rate),
        .o_rsp   (conv_rsp)
    );

    aard_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_gap       (r_merge_gap),
        .o_conv_req  (conv_req),
        .i_conv_rsp  (conv_rsp),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== dv/audio_activity_range_detector_tb.sv =====
// self-checking testbench for the audio activity range detector
module audio_activity_range_detector_tb;
    import aard_pkg::*;

    localparam logic        FUNC_SAMPLE   = ~FUNC_FLUSH;
    localparam logic [63:0] HNS_SEC       = 64'd10000000;
    localparam logic [63:0] TIME_SAT      = 64'(TIME_MAX);
    localparam int          SETTLE_CYCLES = 1000;
    localparam int          STUCK_LIMIT   = 6000;
    localparam int          PHASES        = 9;
    localparam int          PHASE_ITEMS   = 66;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // register copies and activity state for prediction
    logic [THR_W-1:0]  thr_cfg;
    logic [GAP_W-1:0]  gap_cfg;
    logic [RATE_W-1:0] rate_cfg;
    bit                frame_loud = 1'b0;
    bit                run_open   = 1'b0;
    bit                pend_ok    = 1'b0;
    logic [63:0]       run_first  = '0;
    logic [63:0]       run_len    = '0;
    logic [63:0]       pend_start = '0;
    logic [63:0]       pend_dur   = '0;

    t_in_item  request_q[$];
    t_out_item expected_ranges[$];
    t_out_item oldest;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  reqs_queued   = 0;
    int  reqs_taken    = 0;
    int  ranges_seen   = 0;
    int  cfg_writes    = 0;
    int  settings      = 0;
    int  errors        = 0;
    int  stuck_cycles  = 0;
    bit  req_done      = 1'b0;

    audio_activity_range_detector uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] clip_time(input logic [63:0] v);
        return (v > TIME_SAT) ? TIME_SAT : v;
    endfunction

    // frame number to 100 ns units, rounded to nearest with ties up
    function automatic logic [63:0] frames_to_time(input logic [63:0] frames);
        logic [63:0] rate, q, r, frac;
        rate = 64'(rate_cfg);
        if (rate == 0) return 64'd0;
        q    = frames / rate;
        r    = frames % rate;
        frac = (64'd2 * r * HNS_SEC + rate) / (64'd2 * rate);
        if (q > TIME_SAT / HNS_SEC) return TIME_SAT;
        q = q * HNS_SEC;
        if (q + frac > TIME_SAT) return TIME_SAT;
        return q + frac;
    endfunction

    task automatic emit_pending();
        t_out_item r;
        r.range_start_hns    = pend_start[TIME_BITS-1:0];
        r.range_duration_hns = pend_dur[TIME_BITS-1:0];
        expected_ranges = {expected_ranges, r};
    endtask

    task automatic close_activity_run();
        logic [63:0] s, e, d, pend_end, new_end;
        run_open = 1'b0;
        if (run_len == 0) return;
        s = frames_to_time(run_first);
        e = frames_to_time(run_first + run_len);
        d = (e > s) ? e - s : 64'd1;
        run_len = '0;
        if (pend_ok) begin
            pend_end = pend_start + pend_dur;
            // ranges within the gap fold into the pending one, even from behind
            if (s <= pend_end + gap_cfg) begin
                new_end = s + d;
                if (new_end < pend_end) new_end = pend_end;
                d = new_end - pend_start;
                pend_dur = clip_time((d == 0) ? 64'd1 : d);
                return;
            end
            emit_pending();
        end
        pend_ok    = 1'b1;
        pend_start = s;
        pend_dur   = clip_time(d);
    endtask

    task automatic track_activity(input t_in_item it);
        logic [15:0] raw;
        logic [16:0] mag;
        bit          loud;
        if (it.func == FUNC_FLUSH) begin
            if (pend_ok) begin
                emit_pending();
                pend_ok    = 1'b0;
                pend_start = '0;
                pend_dur   = '0;
            end
            return;
        end
        raw = it.sample;
        mag = raw[15] ? 17'h10000 - raw : {1'b0, raw};
        if (mag >= thr_cfg) frame_loud = 1'b1;
        if (!it.frame_end) return;
        loud       = frame_loud;
        frame_loud = 1'b0;
        if (loud) begin
            if (!run_open) begin
                run_open  = 1'b1;
                run_first = 64'(it.frame_index);
                run_len   = '0;
            end
            if (run_len < FRAME_MAX) run_len++;
        end else if (run_open) begin
            close_activity_run();
        end
        if (it.packet_end && run_open) close_activity_run();
    endtask

    task automatic flag_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
        errors++;
        $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic add_req(input logic func, input logic [15:0] smp, input logic [35:0] fr,
                           input logic fe, input logic pe);
        t_in_item it;
        it.func        = func;
        it.sample      = smp;
        it.frame_index = fr;
        it.frame_end   = fe;
        it.packet_end  = pe;
        request_q = {request_q, it};
        reqs_queued++;
    endtask

    // flush with random filler in the ignored fields
    task automatic add_flush();
        add_req(FUNC_FLUSH, 16'($urandom), 36'({$urandom, $urandom}), 1'($urandom),
                1'($urandom));
    endtask

    // sample on the requested side of the threshold, often right at the edge
    function automatic logic [15:0] pick_sample(input bit loud);
        int          lo, hi, m;
        logic [31:0] rnd;
        rnd = $urandom;
        lo  = loud ? int'(thr_cfg) : 0;
        hi  = loud ? 32768 : int'(thr_cfg) - 1;
        if (hi > 32768) hi = 32768;
        if (lo > hi) return rnd[15:0];
        m = $urandom_range(hi, lo);
        if ($urandom_range(3) == 0) m = loud ? lo : hi;
        if (m == 32768) return 16'h8000;
        if (rnd[31]) m = -m;
        return m[15:0];
    endfunction

    task automatic add_traffic(input int count);
        int          made, f, c, nfr, nch, loud_ch;
        logic [63:0] wide;
        logic [35:0] fr;
        bit          loud, pe;
        made = 0;
        fr   = 36'($urandom_range(1 << 20));
        while (made < count) begin
            wide = {$urandom, $urandom};
            case ($urandom_range(19))
                0, 1: begin
                    add_req(($urandom_range(9) == 0) ? FUNC_FLUSH : FUNC_SAMPLE,
                            wide[63:48], wide[35:0], 1'($urandom_range(1)),
                            1'($urandom_range(1)));
                    made++;
                end
                2: begin
                    add_req(FUNC_FLUSH, wide[63:48], wide[35:0], 1'($urandom_range(1)),
                            1'($urandom_range(1)));
                    made++;
                end
                default: begin
                    // one packet of whole frames, channels interleaved
                    nfr = $urandom_range(6, 1);
                    nch = $urandom_range(3, 1);
                    pe  = ($urandom_range(9) < 7);
                    for (f = 0; f < nfr; f++) begin
                        loud    = ($urandom_range(99) < 60);
                        loud_ch = $urandom_range(nch - 1);
                        for (c = 0; c < nch; c++)
                            add_req(FUNC_SAMPLE, pick_sample(loud && c == loud_ch), fr,
                                    c == nch - 1,
                                    (c == nch - 1) ? (pe && f == nfr - 1)
                                                   : ($urandom_range(9) == 0));
                        fr++;
                    end
                    made += nfr * nch;
                    case ($urandom_range(5))
                        0: ;
                        1: fr += 36'($urandom_range(20, 1));
                        2: fr += 36'($urandom_range(5000, 1));
                        3: fr += 36'($urandom_range(200000, 1));
                        4: fr -= 36'($urandom_range(50, 1));
                        default: fr = wide[35:0];
                    endcase
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_THRESHOLD:   thr_cfg  = data[THR_W-1:0];
            CFG_MERGE_GAP:   gap_cfg  = data[GAP_W-1:0];
            CFG_SAMPLE_RATE: rate_cfg = data[RATE_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // hold off until every request is in and every range is out, then let
    // merges with no visible result drain from the back end
    task automatic settle();
        while (reqs_taken != reqs_queued || expected_ranges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            track_activity(i_in_item);
            reqs_taken++;
            req_done = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || req_done)) begin
            req_done = 1'b0;
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_item  <= request_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_ranges.size() == 0) begin
                flag_mismatch("range with none expected, start", o_out_item.range_start_hns,
                              '0);
            end else begin
                oldest = expected_ranges.pop_front();
                ranges_seen++;
                if (o_out_item.range_start_hns !== oldest.range_start_hns)
                    flag_mismatch("range_start_hns", o_out_item.range_start_hns,
                                  oldest.range_start_hns);
                if (o_out_item.range_duration_hns !== oldest.range_duration_hns)
                    flag_mismatch("range_duration_hns", o_out_item.range_duration_hns,
                                  oldest.range_duration_hns);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
        $display("audio_activity_range_detector: mismatch");
        $finish;
    end

    initial begin
        int p;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_THRESHOLD;
        i_cfg_data  = '0;
        thr_cfg     = THRESHOLD_RESET;
        gap_cfg     = MERGE_GAP_RESET;
        rate_cfg    = SAMPLE_RATE_RESET;
        send_idle_pct = 25;
        recv_idle_pct = 62;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // values after reset: flush with nothing pending, extremes, threshold edge
        add_flush();
        add_req(FUNC_SAMPLE, 16'h7fff, 36'd10, 1'b0, 1'b0);
        add_req(FUNC_SAMPLE, 16'h8000, 36'd10, 1'b1, 1'b0);
        add_req(FUNC_SAMPLE, 16'd0, 36'd11, 1'b1, 1'b0);
        add_req(FUNC_SAMPLE, -16'sd512, 36'd20000, 1'b1, 1'b1);
        add_req(FUNC_SAMPLE, 16'd511, 36'd20001, 1'b1, 1'b0);
        // packet end without frame end is dropped, frame stays open
        add_req(FUNC_SAMPLE, 16'd1000, 36'd20002, 1'b0, 1'b1);
        add_req(FUNC_SAMPLE, 16'd0, 36'd20002, 1'b1, 1'b0);
        // flush leaves the open run alone
        add_flush();
        add_req(FUNC_SAMPLE, 16'd0, 36'd20003, 1'b1, 1'b1);
        // earlier frame still inside the gap merges
        add_req(FUNC_SAMPLE, 16'd30000, 36'd19990, 1'b1, 1'b1);
        add_flush();
        add_flush();
        settle();

        // zero threshold, zero gap, slowest rate: saturated times
        write_reg(CFG_THRESHOLD, 27'd0);
        write_reg(CFG_MERGE_GAP, 27'd0);
        write_reg(CFG_SAMPLE_RATE, 27'd1);
        add_req(FUNC_SAMPLE, 16'd0, FRAME_MAX, 1'b1, 1'b1);
        add_req(FUNC_SAMPLE, 16'd0, 36'd0, 1'b1, 1'b1);
        add_flush();
        settle();

        // zero rate maps every frame to time 0
        write_reg(CFG_SAMPLE_RATE, 27'd0);
        add_req(FUNC_SAMPLE, 16'd5, 36'd123, 1'b1, 1'b1);
        add_flush();
        settle();

        // threshold above full scale never fires
        write_reg(CFG_THRESHOLD, 27'd65535);
        write_reg(CFG_MERGE_GAP, 27'h7ffffff);
        write_reg(CFG_SAMPLE_RATE, 27'd384000);
        add_req(FUNC_SAMPLE, 16'h8000, 36'd7, 1'b1, 1'b1);
        add_flush();
        settle();

        write_reg(CFG_THRESHOLD, 27'd32768);
        add_req(FUNC_SAMPLE, 16'h8000, 36'd7, 1'b1, 1'b0);
        add_req(FUNC_SAMPLE, 16'h7fff, 36'd8, 1'b1, 1'b1);
        add_flush();
        settle();
        settings = 5;

        for (p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 25;
                recv_idle_pct = 62;
            end else if (p < 6) begin
                send_idle_pct = 62;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: begin
                    write_reg(CFG_THRESHOLD, CFG_DATA_W'(THRESHOLD_RESET));
                    write_reg(CFG_MERGE_GAP, CFG_DATA_W'(MERGE_GAP_RESET));
                    write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'(SAMPLE_RATE_RESET));
                end
                1: begin
                    write_reg(CFG_THRESHOLD, 27'd0);
                    write_reg(CFG_MERGE_GAP, 27'd0);
                    write_reg(CFG_SAMPLE_RATE, 27'd384000);
                end
                2: begin
                    write_reg(CFG_THRESHOLD, 27'd32768);
                    write_reg(CFG_MERGE_GAP, 27'd100000000);
                    write_reg(CFG_SAMPLE_RATE, 27'd1);
                end
                default: begin
                    case ($urandom_range(3))
                        0: write_reg(CFG_THRESHOLD, 27'd1);
                        1: write_reg(CFG_THRESHOLD, 27'($urandom_range(32768)));
                        2: write_reg(CFG_THRESHOLD, 27'($urandom_range(4096)));
                        default: write_reg(CFG_THRESHOLD, 27'd512);
                    endcase
                    case ($urandom_range(3))
                        0: write_reg(CFG_MERGE_GAP, 27'd0);
                        1: write_reg(CFG_MERGE_GAP, 27'($urandom_range(100000000)));
                        2: write_reg(CFG_MERGE_GAP, 27'($urandom_range(1000000)));
                        default: write_reg(CFG_MERGE_GAP, 27'h7ffffff);
                    endcase
                    case ($urandom_range(3))
                        0: write_reg(CFG_SAMPLE_RATE, 27'($urandom_range(384000, 1)));
                        1: write_reg(CFG_SAMPLE_RATE, 27'd44100);
                        2: write_reg(CFG_SAMPLE_RATE, 27'd8000);
                        default: write_reg(CFG_SAMPLE_RATE, 27'd384000);
                    endcase
                end
            endcase
            settings++;
            add_traffic(PHASE_ITEMS);
            add_flush();
            settle();
        end

        $display("covered %0d requests over %0d register settings (%0d writes)",
                 reqs_taken, settings, cfg_writes);
        $display("checked %0d activity ranges, %0d mismatches", ranges_seen, errors);
        if (errors == 0)
            $display("audio_activity_range_detector: match");
        else
            $display("audio_activity_range_detector: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/aard_pkg.sv
hdl/aard_fifo.sv
hdl/aard_front.sv
hdl/aard_conv.sv
hdl/aard_back.sv
hdl/audio_activity_range_detector.sv
dv/audio_activity_range_detector_tb.sv
